// File: hdl/balu_pkg.sv
// balu_pkg: shared types and constants for the bitwise integer alu
// operation codes, request and response beat structs; no dependencies
package balu_pkg;

  localparam int unsigned Width     = 32;
  localparam int unsigned HalfWidth = Width / 2;
  localparam int unsigned ShiftBits = 5;
  localparam int unsigned FuncBits  = 4;

  typedef enum logic [FuncBits-1:0] {
    FUNC_NEG   = 4'd0,
    FUNC_INC   = 4'd1,
    FUNC_DEC   = 4'd2,
    FUNC_ADD   = 4'd3,
    FUNC_SUB   = 4'd4,
    FUNC_MUL   = 4'd5,
    FUNC_SHL   = 4'd6,
    FUNC_SAR   = 4'd7,
    FUNC_SPLIT = 4'd8
  } balu_func_e;

  typedef struct packed {
    balu_func_e           func;
    logic [Width-1:0]     operand_a;
    logic [Width-1:0]     operand_b;
    logic [ShiftBits-1:0] shift_amount;
  } balu_req_t;

  typedef struct packed {
    logic [Width-1:0] result;
    logic [Width-1:0] result_low;
  } balu_rsp_t;

endpackage

// File: hdl/bitwise_integer_alu.sv
// bitwise_integer_alu: three-stage pipelined 32-bit integer alu
// depends on balu_pkg for the beat structs and operation codes
//
// usage: a request beat (func, operand_a, operand_b, shift_amount) enters on
// in_valid_i/in_ready_o, one response beat (result, result_low) leaves on
// out_valid_o/out_ready_i per request, in request order.
// stages: 1 registers the simple results (neg, inc, dec, add, sub, shifts,
// split) and the three 16x16 partial products of the multiply; 2 folds the
// cross products into the low product and picks the result; 3 is the output
// register that holds the response until the receiver takes it.
// order: a request moves from stage 1 to stage 2 to the output register, and a
// stall can hold it in any of them before the receiver takes it.
// throughput: one beat per cycle while out_ready_i is high; each stage advances
// when it is empty or the stage after it advances, so bubbles are squeezed out during a stall.
// when out_ready_i is low the output holds and up to three beats stay in
// flight; in_ready_o drops only once all three stages are full.
// reset clears the stage valid bits only; the payload registers are not reset.
module bitwise_integer_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  balu_pkg::balu_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output balu_pkg::balu_rsp_t out_rsp_o
);
  import balu_pkg::*;

  // stage valid bits and advance enables
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  // stage 1 payload
  balu_func_e             func1_q;
  logic [Width-1:0]       res1_d, res1_q;
  logic [Width-1:0]       low1_d, low1_q;
  logic [Width-1:0]       pp_ll_q;
  logic [HalfWidth-1:0]   pp_lh_q, pp_hl_q;

  // stage 2 payload
  logic [Width-1:0]       prod2;
  logic [HalfWidth-1:0]   cross2;
  logic [Width-1:0]       res2_d, res2_q;
  logic [Width-1:0]       low2_q;
  logic                   split2_q;

  // stage 3 payload
  balu_rsp_t              rsp3_q;

  assign en3        = v2_q && (!v3_q || out_ready_i);
  assign en2        = v1_q && (!v2_q || en3 || !v3_q || out_ready_i);
  assign en1        = in_valid_i && in_ready_o;
  assign in_ready_o = !v1_q || en2;

  // stage 1: everything but the multiply finishes here
  always_comb begin
    res1_d = '0;
    low1_d = '0;
    case (in_req_i.func)
      FUNC_NEG:   res1_d = Width'(0) - in_req_i.operand_a;
      FUNC_INC:   res1_d = in_req_i.operand_a + Width'(1);
      FUNC_DEC:   res1_d = in_req_i.operand_a - Width'(1);
      FUNC_ADD:   res1_d = in_req_i.operand_a + in_req_i.operand_b;
      FUNC_SUB:   res1_d = in_req_i.operand_a - in_req_i.operand_b;
      FUNC_SHL:   res1_d = in_req_i.operand_a << in_req_i.shift_amount;
      FUNC_SAR:   res1_d = Width'($signed(in_req_i.operand_a) >>> in_req_i.shift_amount);
      FUNC_SPLIT: begin
        res1_d = {in_req_i.operand_a[Width-1:HalfWidth], {HalfWidth{1'b0}}};
        low1_d = {{HalfWidth{1'b0}}, in_req_i.operand_a[HalfWidth-1:0]};
      end
      default:    res1_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_ready_o) v1_q <= in_valid_i;
      if (!v2_q || en3 || out_ready_i || !v3_q) v2_q <= v1_q && en2 ? 1'b1 : (en3 ? 1'b0 : v2_q);
      if (!v3_q || out_ready_i) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      func1_q <= in_req_i.func;
      res1_q  <= res1_d;
      low1_q  <= low1_d;
      pp_ll_q <= in_req_i.operand_a[HalfWidth-1:0] * in_req_i.operand_b[HalfWidth-1:0];
      pp_lh_q <= HalfWidth'(in_req_i.operand_a[HalfWidth-1:0]
                            * in_req_i.operand_b[Width-1:HalfWidth]);
      pp_hl_q <= HalfWidth'(in_req_i.operand_a[Width-1:HalfWidth]
                            * in_req_i.operand_b[HalfWidth-1:0]);
    end
  end

  // stage 2: low product = ll + (lh + hl) << half
  assign cross2 = pp_lh_q + pp_hl_q;
  assign prod2  = pp_ll_q + {cross2, {HalfWidth{1'b0}}};
  assign res2_d = (func1_q == FUNC_MUL) ? prod2 : res1_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      res2_q   <= res2_d;
      low2_q   <= low1_q;
      split2_q <= (func1_q == FUNC_SPLIT);
    end
  end

  // stage 3: output register
  always_ff @(posedge clk_i) begin
    if (en3) begin
      rsp3_q.result     <= res2_q;
      rsp3_q.result_low <= low2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_rsp_o   = rsp3_q;

`ifndef NO_ASSERTIONS
  // only split produces a nonzero low half
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !split2_q |-> low2_q == '0)
    else $error("low half nonzero outside split");

  // a held response is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !out_ready_i |=> v3_q && $stable(rsp3_q))
    else $error("stalled response changed");

  // a full stage 2 with a stalled output keeps its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && v3_q && !out_ready_i |=> v2_q && $stable(res2_q))
    else $error("stage 2 beat lost during stall");

  // input is refused only when every stage is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v1_q && v2_q && v3_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
